/* src/cruijff_lineshape_eval_assert.svh */
// Assertion macros for the line-shape evaluator RTL.
`ifndef CRUIJFF_LINESHAPE_EVAL_ASSERT_SVH
`define CRUIJFF_LINESHAPE_EVAL_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define CLE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define CLE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/cle_pkg.sv */
// Shared types and constants of the line-shape evaluator.
`default_nettype none

package cle_pkg;

    // Default fixed-point format and exponential table size.
    localparam int FRAC_BITS_DEF  = 16;
    localparam int EXP_DEPTH_DEF  = 256;
    localparam int RATIO_INT_BITS = 6;

    // log2(e) and ln(2) scaled by 2^32.
    localparam logic [63:0] LOG2E_Q32 = 64'd6196328019;
    localparam logic [63:0] LN2_Q32   = 64'd2977044472;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        REG_PEAK_MEAN   = 3'd0,
        REG_LEFT_WIDTH  = 3'd1,
        REG_RIGHT_WIDTH = 3'd2,
        REG_LEFT_TAIL   = 3'd3,
        REG_PEAK_HEIGHT = 3'd4
    } cle_reg_e;

    // Power-of-two scale carried alongside the mantissa.
    typedef struct packed {
        logic       raise;
        logic [7:0] mag;
    } cle_scale_t;

endpackage

`default_nettype wire

/* src/cruijff_lineshape_eval.sv */
// Top level of the Cruijff line-shape evaluator.
// Samples and parameters are fixed point with FRAC_BITS fraction bits (Q16.16 by default).
// Throughput: one sample per cycle while sample_stall is low; the divider takes one quotient bit per pipeline stage.
// A two-word output buffer absorbs a stall; sample_stall rises only while it is full.
// Reset: asynchronous; configuration returns to mean 0, widths 1.0, tail 0, height 1.0,
// and all pipeline valid bits clear at once.
`default_nettype none

`include "cruijff_lineshape_eval_assert.svh"

module cruijff_lineshape_eval #(
    parameter int FRAC_BITS = cle_pkg::FRAC_BITS_DEF,
    parameter int EXP_DEPTH = cle_pkg::EXP_DEPTH_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               sample_valid,
    output logic                    sample_stall,
    input  wire logic signed [31:0] sample_x,
    output logic                    result_valid,
    input  wire logic               result_stall,
    output logic [31:0]             shape_value,
    output logic                    saturated,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [31:0]        cfg_data
);

    localparam int Q_W     = FRAC_BITS + cle_pkg::RATIO_INT_BITS;
    localparam int SIGSH_W = 64 + FRAC_BITS + 1;
    localparam int DEN_W   = ((SIGSH_W > 96) ? SIGSH_W : 96) + 1;
    localparam int NUM_W   = 64 + 2 * FRAC_BITS;
    localparam int TP_W    = Q_W + 34;
    localparam int T_W     = Q_W + 1;
    localparam logic [31:0] ONE_FX = 32'(64'd1 << FRAC_BITS);

    // Configuration registers.
    logic [31:0] mean_reg;
    logic [31:0] lw_reg;
    logic [31:0] rw_reg;
    logic [31:0] tail_reg;
    logic [31:0] height_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mean_reg   <= '0;
            lw_reg     <= ONE_FX;
            rw_reg     <= ONE_FX;
            tail_reg   <= '0;
            height_reg <= ONE_FX;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cle_pkg::cle_reg_e'(cfg_index))
                cle_pkg::REG_PEAK_MEAN:   mean_reg   <= cfg_data;
                cle_pkg::REG_LEFT_WIDTH:  lw_reg     <= cfg_data;
                cle_pkg::REG_RIGHT_WIDTH: rw_reg     <= cfg_data;
                cle_pkg::REG_LEFT_TAIL:   tail_reg   <= cfg_data;
                cle_pkg::REG_PEAK_HEIGHT: height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Pipeline enable follows the output buffer fill only.
    logic [1:0] cnt_reg;
    logic       en;

    assign en           = (cnt_reg != 2'd2);
    assign sample_stall = !en;

    // Stage 1: distance from the mean, side, width and tail magnitude.
    logic [32:0] d_diff;
    logic [32:0] d_neg;
    logic [31:0] tail_neg;

    assign d_diff   = {sample_x[31], sample_x} - {mean_reg[31], mean_reg};
    assign d_neg    = 33'd0 - d_diff;
    assign tail_neg = 32'd0 - tail_reg;

    logic        s1_v_reg;
    logic        s1_left_reg;
    logic [31:0] s1_dm_reg;
    logic [31:0] s1_sig_reg;
    logic [31:0] s1_am_reg;
    logic        s1_aneg_reg;

    // Stage 2: squared distance and squared width.
    logic [63:0] s2_sq_next;
    logic [63:0] s2_sig2_next;
    logic        s2_v_reg;
    logic        s2_left_reg;
    logic [63:0] s2_sq_reg;
    logic [63:0] s2_sig2_reg;
    logic [31:0] s2_am_reg;
    logic        s2_aneg_reg;

    assign s2_sq_next   = 64'(s1_dm_reg) * 64'(s1_dm_reg);
    assign s2_sig2_next = 64'(s1_sig_reg) * 64'(s1_sig_reg);

    // Stage 3: tail term as two partial products.
    logic [63:0] s3_lo_next;
    logic [63:0] s3_hi_next;
    logic        s3_v_reg;
    logic        s3_left_reg;
    logic [63:0] s3_sq_reg;
    logic [63:0] s3_sig2_reg;
    logic [63:0] s3_lo_reg;
    logic [63:0] s3_hi_reg;
    logic        s3_aneg_reg;

    assign s3_lo_next = 64'(s2_am_reg) * 64'(s2_sq_reg[31:0]);
    assign s3_hi_next = 64'(s2_am_reg) * 64'(s2_sq_reg[63:32]);

    // Stage 4: combine the partial products.
    logic [95:0] s4_tt_next;
    logic        s4_v_reg;
    logic        s4_left_reg;
    logic [63:0] s4_sq_reg;
    logic [63:0] s4_sig2_reg;
    logic [95:0] s4_tt_reg;
    logic        s4_aneg_reg;

    assign s4_tt_next = {32'd0, s3_lo_reg} + {s3_hi_reg, 32'd0};

    // Stage 5: positive and negative parts of the denominator.
    logic [DEN_W-1:0] s5_pos_next;
    logic [95:0]      s5_neg_next;
    logic             s5_v_reg;
    logic [63:0]      s5_sq_reg;
    logic [DEN_W-1:0] s5_pos_reg;
    logic [95:0]      s5_neg_reg;

    assign s5_pos_next = (DEN_W'(s4_sig2_reg) << (FRAC_BITS + 1))
                         + ((s4_left_reg && !s4_aneg_reg) ? DEN_W'(s4_tt_reg) : '0);
    assign s5_neg_next = (s4_left_reg && s4_aneg_reg) ? s4_tt_reg : '0;

    // Stage 6: magnitude of the denominator; a negative one raises the exponent.
    logic [DEN_W:0]   s6_dif;
    logic [DEN_W:0]   s6_dif_neg;
    logic             s6_v_reg;
    logic [63:0]      s6_sq_reg;
    logic [DEN_W-1:0] s6_den_reg;
    logic             s6_raise_reg;

    assign s6_dif     = {1'b0, s5_pos_reg} - {1'b0, DEN_W'(s5_neg_reg)};
    assign s6_dif_neg = '0 - s6_dif;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            s3_v_reg <= 1'b0;
            s4_v_reg <= 1'b0;
            s5_v_reg <= 1'b0;
            s6_v_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_v_reg <= sample_valid;
            s2_v_reg <= s1_v_reg;
            s3_v_reg <= s2_v_reg;
            s4_v_reg <= s3_v_reg;
            s5_v_reg <= s4_v_reg;
            s6_v_reg <= s5_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_left_reg  <= d_diff[32];
            s1_dm_reg    <= d_diff[32] ? d_neg[31:0] : d_diff[31:0];
            s1_sig_reg   <= d_diff[32] ? lw_reg : rw_reg;
            s1_am_reg    <= tail_reg[31] ? tail_neg : tail_reg;
            s1_aneg_reg  <= tail_reg[31];

            s2_left_reg  <= s1_left_reg;
            s2_sq_reg    <= s2_sq_next;
            s2_sig2_reg  <= s2_sig2_next;
            s2_am_reg    <= s1_am_reg;
            s2_aneg_reg  <= s1_aneg_reg;

            s3_left_reg  <= s2_left_reg;
            s3_sq_reg    <= s2_sq_reg;
            s3_sig2_reg  <= s2_sig2_reg;
            s3_lo_reg    <= s3_lo_next;
            s3_hi_reg    <= s3_hi_next;
            s3_aneg_reg  <= s2_aneg_reg;

            s4_left_reg  <= s3_left_reg;
            s4_sq_reg    <= s3_sq_reg;
            s4_sig2_reg  <= s3_sig2_reg;
            s4_tt_reg    <= s4_tt_next;
            s4_aneg_reg  <= s3_aneg_reg;

            s5_sq_reg    <= s4_sq_reg;
            s5_pos_reg   <= s5_pos_next;
            s5_neg_reg   <= s5_neg_next;

            s6_sq_reg    <= s5_sq_reg;
            s6_den_reg   <= s6_dif[DEN_W] ? s6_dif_neg[DEN_W-1:0] : s6_dif[DEN_W-1:0];
            s6_raise_reg <= s6_dif[DEN_W];
        end
    end

    // Ratio d^2/|den| in Q.F, clipped below 2^RATIO_INT_BITS.
    logic           q_valid;
    logic [Q_W-1:0] q_val;
    logic           q_raise;

    cle_ratio_div #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W),
        .Q_W   (Q_W)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s6_v_reg),
        .num       (NUM_W'(s6_sq_reg) << (2 * FRAC_BITS)),
        .den       (s6_den_reg),
        .in_raise  (s6_raise_reg),
        .out_valid (q_valid),
        .q         (q_val),
        .out_raise (q_raise)
    );

    // T1: convert to a base-two exponent with round half up.
    logic [TP_W-1:0] t1_prod_next;
    logic            t1_v_reg;
    logic [TP_W-1:0] t1_prod_reg;
    logic            t1_raise_reg;

    assign t1_prod_next = TP_W'(q_val) * TP_W'(cle_pkg::LOG2E_Q32) + (TP_W'(1) << 31);

    // T2: integer and fraction split; for a raised exponent the fraction is folded to 1 - f.
    logic [T_W-1:0]       t2_t;
    logic [6:0]           t2_n;
    logic [FRAC_BITS-1:0] t2_f;
    logic                 t2_byp_next;
    cle_pkg::cle_scale_t  t2_tag_next;
    logic                 t2_v_reg;
    logic [FRAC_BITS-1:0] t2_u_reg;
    logic                 t2_byp_reg;
    cle_pkg::cle_scale_t  t2_tag_reg;

    assign t2_t        = t1_prod_reg[32 +: T_W];
    assign t2_n        = t2_t[FRAC_BITS +: 7];
    assign t2_f        = t2_t[FRAC_BITS-1:0];
    assign t2_byp_next = t1_raise_reg && (t2_f == '0);
    assign t2_tag_next.raise = t1_raise_reg;
    assign t2_tag_next.mag   = (t1_raise_reg && !t2_byp_next) ? ({1'b0, t2_n} + 8'd1)
                                                              : {1'b0, t2_n};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t1_v_reg <= 1'b0;
            t2_v_reg <= 1'b0;
        end
        else if (en)
        begin
            t1_v_reg <= q_valid;
            t2_v_reg <= t1_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t1_prod_reg  <= t1_prod_next;
            t1_raise_reg <= q_raise;
            t2_u_reg     <= t1_raise_reg ? ('0 - t2_f) : t2_f;
            t2_byp_reg   <= t2_byp_next;
            t2_tag_reg   <= t2_tag_next;
        end
    end

    // Mantissa 2^-u in Q1.32.
    logic                g_valid;
    logic [32:0]         g;
    cle_pkg::cle_scale_t g_tag;

    cle_exp2_interp #(
        .FRAC_BITS (FRAC_BITS),
        .EXP_DEPTH (EXP_DEPTH)
    ) u_exp (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (t2_v_reg),
        .u         (t2_u_reg),
        .bypass    (t2_byp_reg),
        .tag_in    (t2_tag_reg),
        .out_valid (g_valid),
        .g         (g),
        .tag_out   (g_tag)
    );

    // P1: amplitude times mantissa.
    logic                p1_v_reg;
    logic [63:0]         p1_prod_reg;
    cle_pkg::cle_scale_t p1_tag_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_v_reg <= 1'b0;
        end
        else if (en)
        begin
            p1_v_reg <= g_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1_prod_reg <= 64'(height_reg) * 64'(g);
            p1_tag_reg  <= g_tag;
        end
    end

    // Final power-of-two scaling with saturation.
    logic [5:0]  sh;
    logic        over;
    logic        under;
    logic [63:0] shifted;
    logic [31:0] word_val;
    logic        word_sat;

    always_comb
    begin
        sh    = 6'd0;
        over  = 1'b0;
        under = 1'b0;
        if (p1_tag_reg.raise)
        begin
            if (p1_tag_reg.mag > 8'd32)
            begin
                over = 1'b1;
            end
            else
            begin
                sh = 6'(8'd32 - p1_tag_reg.mag);
            end
        end
        else
        begin
            if (p1_tag_reg.mag >= 8'd32)
            begin
                under = 1'b1;
            end
            else
            begin
                sh = 6'(8'd32 + p1_tag_reg.mag);
            end
        end
        shifted = p1_prod_reg >> sh;
        if (over)
        begin
            word_sat = (p1_prod_reg != '0);
            word_val = word_sat ? 32'hFFFF_FFFF : 32'd0;
        end
        else if (under)
        begin
            word_sat = 1'b0;
            word_val = 32'd0;
        end
        else
        begin
            word_sat = (shifted[63:32] != '0);
            word_val = word_sat ? 32'hFFFF_FFFF : shifted[31:0];
        end
    end

    // Two-word output buffer: head drives the ports, spare catches a word during a stall.
    logic        push;
    logic        pop;
    logic [1:0]  cnt_next;
    logic [31:0] head_val_reg;
    logic        head_sat_reg;
    logic [31:0] spare_val_reg;
    logic        spare_sat_reg;
    logic [31:0] head_val_next;
    logic        head_sat_next;
    logic [31:0] spare_val_next;
    logic        spare_sat_next;

    assign result_valid = (cnt_reg != 2'd0);
    assign push         = en && p1_v_reg;
    assign pop          = result_valid && !result_stall;

    always_comb
    begin
        cnt_next       = cnt_reg;
        head_val_next  = head_val_reg;
        head_sat_next  = head_sat_reg;
        spare_val_next = spare_val_reg;
        spare_sat_next = spare_sat_reg;
        unique case ({push, pop})
            2'b10:
            begin
                cnt_next = cnt_reg + 2'd1;
                if (cnt_reg == 2'd0)
                begin
                    head_val_next = word_val;
                    head_sat_next = word_sat;
                end
                else
                begin
                    spare_val_next = word_val;
                    spare_sat_next = word_sat;
                end
            end
            2'b01:
            begin
                cnt_next      = cnt_reg - 2'd1;
                head_val_next = spare_val_reg;
                head_sat_next = spare_sat_reg;
            end
            2'b11:
            begin
                head_val_next = word_val;
                head_sat_next = word_sat;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        head_val_reg  <= head_val_next;
        head_sat_reg  <= head_sat_next;
        spare_val_reg <= spare_val_next;
        spare_sat_reg <= spare_sat_next;
    end

    assign shape_value = head_val_reg;
    assign saturated   = head_sat_reg;

    // Checks on the buffer and the scaling path.
    `CLE_ASSERT_NOW(a_sat_all_ones, result_valid && saturated, shape_value == 32'hFFFF_FFFF, "saturated word is not all ones")
    `CLE_ASSERT_NOW(a_cnt_range, 1'b1, cnt_reg != 2'd3, "output buffer count out of range")
    `CLE_ASSERT_NOW(a_g_bound, g_valid && g[32], g[31:0] == 32'd0, "mantissa exceeds one")
    `CLE_ASSERT_NEXT(a_full_holds, (cnt_reg == 2'd2) && result_stall, (cnt_reg == 2'd2) && $stable(shape_value), "full buffer lost a word under stall")

endmodule

`default_nettype wire

/* src/cle_ratio_div.sv */
// Pipelined restoring divider forming the clipped ratio numerator/denominator.
`default_nettype none

module cle_ratio_div #(
    parameter int NUM_W = 64 + 2 * cle_pkg::FRAC_BITS_DEF,
    parameter int DEN_W = 97,
    parameter int Q_W   = cle_pkg::FRAC_BITS_DEF + cle_pkg::RATIO_INT_BITS
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             en,
    input  wire logic             in_valid,
    input  wire logic [NUM_W-1:0] num,
    input  wire logic [DEN_W-1:0] den,
    input  wire logic             in_raise,
    output logic                  out_valid,
    output logic [Q_W-1:0]        q,
    output logic                  out_raise
);

    localparam int CMP_W = ((DEN_W + Q_W) > NUM_W) ? (DEN_W + Q_W) : NUM_W;

    // Stage 0 holds the clip and zero checks; stage j has resolved j quotient bits.
    logic [Q_W:0]       v_reg;
    logic [NUM_W-1:0]   rem_reg   [Q_W];
    logic [DEN_W-1:0]   den_reg   [Q_W];
    logic [Q_W-1:0]     q_reg     [Q_W+1];
    logic [Q_W:0]       clip_reg;
    logic [Q_W:0]       zero_reg;
    logic [Q_W:0]       raise_reg;

    logic clip_next;
    logic zero_next;

    // A quotient that would not fit saturates; a zero denominator gives zero.
    assign clip_next = CMP_W'(num) >= (CMP_W'(den) << Q_W);
    assign zero_next = (den == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            v_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]   <= num;
            den_reg[0]   <= den;
            q_reg[0]     <= '0;
            clip_reg[0]  <= clip_next;
            zero_reg[0]  <= zero_next;
            raise_reg[0] <= in_raise;
        end
    end

    // One quotient bit per stage, most significant first.
    for (genvar j = 0; j < Q_W; j++)
    begin : g_bit
        localparam int B = Q_W - 1 - j;

        logic [CMP_W-1:0] shifted;
        logic [CMP_W-1:0] diff;
        logic             ge;

        assign shifted = CMP_W'(den_reg[j]) << B;
        assign ge      = CMP_W'(rem_reg[j]) >= shifted;
        assign diff    = CMP_W'(rem_reg[j]) - shifted;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[j+1] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[j+1] <= v_reg[j];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                q_reg[j+1]     <= ge ? (q_reg[j] | (Q_W'(1) << B)) : q_reg[j];
                clip_reg[j+1]  <= clip_reg[j];
                zero_reg[j+1]  <= zero_reg[j];
                raise_reg[j+1] <= raise_reg[j];
            end
        end

        if (j < Q_W - 1)
        begin : g_rem
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[j+1] <= ge ? diff[NUM_W-1:0] : rem_reg[j];
                    den_reg[j+1] <= den_reg[j];
                end
            end
        end
    end

    // Apply the special cases on the way out.
    assign out_valid = v_reg[Q_W];
    assign out_raise = raise_reg[Q_W];
    assign q = zero_reg[Q_W] ? '0 : (clip_reg[Q_W] ? '1 : q_reg[Q_W]);

endmodule

`default_nettype wire

/* src/cle_exp2_interp.sv */
// Interpolated 2^-u lookup over a constant table, three register stages.
`default_nettype none

module cle_exp2_interp #(
    parameter int FRAC_BITS = cle_pkg::FRAC_BITS_DEF,
    parameter int EXP_DEPTH = cle_pkg::EXP_DEPTH_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 en,
    input  wire logic                 in_valid,
    input  wire logic [FRAC_BITS-1:0] u,
    input  wire logic                 bypass,
    input  wire cle_pkg::cle_scale_t  tag_in,
    output logic                      out_valid,
    output logic [32:0]               g,
    output cle_pkg::cle_scale_t       tag_out
);

    localparam int IDX_W = $clog2(EXP_DEPTH + 1);
    localparam int DEP_W = $clog2(EXP_DEPTH) + 1;
    localparam int P_W   = FRAC_BITS + DEP_W;
    localparam int DP_W  = 33 + FRAC_BITS;
    localparam logic [32:0] ONE_G = 33'h1_0000_0000;

    // Table entry i is 2^(-i/EXP_DEPTH) in Q1.32 from an alternating series of exp(-y).
    function automatic logic [32:0] rom_entry(input int unsigned idx);
        logic [63:0] y;
        logic [63:0] term;
        logic [63:0] sum;
        y    = (64'(idx) * cle_pkg::LN2_Q32) / 64'(EXP_DEPTH);
        term = 64'd1 << 32;
        sum  = term;
        term = ((term * y) >> 32) / 64'd1;  sum = sum - term;
        term = ((term * y) >> 32) / 64'd2;  sum = sum + term;
        term = ((term * y) >> 32) / 64'd3;  sum = sum - term;
        term = ((term * y) >> 32) / 64'd4;  sum = sum + term;
        term = ((term * y) >> 32) / 64'd5;  sum = sum - term;
        term = ((term * y) >> 32) / 64'd6;  sum = sum + term;
        term = ((term * y) >> 32) / 64'd7;  sum = sum - term;
        term = ((term * y) >> 32) / 64'd8;  sum = sum + term;
        term = ((term * y) >> 32) / 64'd9;  sum = sum - term;
        term = ((term * y) >> 32) / 64'd10; sum = sum + term;
        term = ((term * y) >> 32) / 64'd11; sum = sum - term;
        term = ((term * y) >> 32) / 64'd12; sum = sum + term;
        term = ((term * y) >> 32) / 64'd13; sum = sum - term;
        term = ((term * y) >> 32) / 64'd14; sum = sum + term;
        term = ((term * y) >> 32) / 64'd15; sum = sum - term;
        term = ((term * y) >> 32) / 64'd16; sum = sum + term;
        term = ((term * y) >> 32) / 64'd17; sum = sum - term;
        term = ((term * y) >> 32) / 64'd18; sum = sum + term;
        term = ((term * y) >> 32) / 64'd19; sum = sum - term;
        term = ((term * y) >> 32) / 64'd20; sum = sum + term;
        return sum[32:0];
    endfunction

    logic [32:0] rom_w [EXP_DEPTH+1];

    for (genvar gi = 0; gi <= EXP_DEPTH; gi++)
    begin : g_rom
        assign rom_w[gi] = rom_entry(gi);
    end

    // Stage 1: split u*EXP_DEPTH into table index and weight, read both neighbors.
    logic [P_W-1:0]       pos;
    logic [IDX_W-1:0]     idx;
    logic [IDX_W-1:0]     idx_up;

    assign pos    = P_W'(u) * P_W'(EXP_DEPTH);
    assign idx    = IDX_W'(pos >> FRAC_BITS);
    assign idx_up = idx + IDX_W'(1);

    logic                 e1_v_reg;
    logic [32:0]          e1_t0_reg;
    logic [32:0]          e1_t1_reg;
    logic [FRAC_BITS-1:0] e1_w_reg;
    logic                 e1_byp_reg;
    cle_pkg::cle_scale_t  e1_tag_reg;

    // Stage 2: weighted step between the two entries.
    logic [DP_W-1:0]      e2_dp_next;
    logic                 e2_v_reg;
    logic [DP_W-1:0]      e2_dp_reg;
    logic [32:0]          e2_t0_reg;
    logic                 e2_byp_reg;
    cle_pkg::cle_scale_t  e2_tag_reg;

    assign e2_dp_next = DP_W'(e1_t0_reg - e1_t1_reg) * DP_W'(e1_w_reg);

    // Stage 3: final mantissa, exactly one for an integer positive exponent.
    logic [32:0]          e3_g_next;
    logic                 e3_v_reg;
    logic [32:0]          e3_g_reg;
    cle_pkg::cle_scale_t  e3_tag_reg;

    assign e3_g_next = e2_byp_reg ? ONE_G : (e2_t0_reg - 33'(e2_dp_reg >> FRAC_BITS));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e1_v_reg <= 1'b0;
            e2_v_reg <= 1'b0;
            e3_v_reg <= 1'b0;
        end
        else if (en)
        begin
            e1_v_reg <= in_valid;
            e2_v_reg <= e1_v_reg;
            e3_v_reg <= e2_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e1_t0_reg  <= rom_w[idx];
            e1_t1_reg  <= rom_w[idx_up];
            e1_w_reg   <= pos[FRAC_BITS-1:0];
            e1_byp_reg <= bypass;
            e1_tag_reg <= tag_in;
            e2_dp_reg  <= e2_dp_next;
            e2_t0_reg  <= e1_t0_reg;
            e2_byp_reg <= e1_byp_reg;
            e2_tag_reg <= e1_tag_reg;
            e3_g_reg   <= e3_g_next;
            e3_tag_reg <= e2_tag_reg;
        end
    end

    assign out_valid = e3_v_reg;
    assign g         = e3_g_reg;
    assign tag_out   = e3_tag_reg;

endmodule

`default_nettype wire

/* tb/tb_top.sv */
// Self-checking testbench for the Cruijff line-shape evaluator.
`timescale 1ns / 100ps
`default_nettype none

module tb_top;

    localparam int          FRAC       = cle_pkg::FRAC_BITS_DEF;
    localparam int          DEPTH      = cle_pkg::EXP_DEPTH_DEF;
    localparam logic [2:0]  REG_SPARE  = 3'd7;
    localparam logic [31:0] ONE_Q      = 32'h0001_0000;
    localparam int          DRAIN_WAIT = 60;
    localparam int          CYCLE_CAP  = 2000000;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               sample_valid = 1'b0;
    logic               sample_stall;
    logic signed [31:0] sample_x = '0;
    logic               result_valid;
    logic               result_stall = 1'b0;
    logic [31:0]        shape_value;
    logic               saturated;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [2:0]         cfg_index = '0;
    logic [31:0]        cfg_data = '0;

    // Shadow copy of the peak parameters.
    logic signed [31:0] mean_q   = 0;
    logic [31:0]        lwidth_q = ONE_Q;
    logic [31:0]        rwidth_q = ONE_Q;
    logic signed [31:0] tail_q   = 0;
    logic [31:0]        height_q = ONE_Q;

    logic [63:0] pow2_rom [0:DEPTH];
    logic [31:0] want_value_q [$];
    logic        want_sat_q [$];
    int          mismatches = 0;
    int          burst_left = 0;
    int          max_gap = 4;
    bit          hold_req = 0;
    int          hold_cnt = 0;
    int          stall_mode = 0;
    int          mode_cnt = 0;
    int          cycles = 0;

    cruijff_lineshape_eval dut (
        .clk(clk), .rst_n(rst_n),
        .sample_valid(sample_valid), .sample_stall(sample_stall), .sample_x(sample_x),
        .result_valid(result_valid), .result_stall(result_stall),
        .shape_value(shape_value), .saturated(saturated),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #4 clk = ~clk;

    // Table of 2^(-i/DEPTH) in Q1.32 from an alternating series of exp(-y).
    function automatic void build_pow2_rom();
        logic [63:0] y;
        logic [63:0] term;
        logic [63:0] sum;
        for (int i = 0; i <= DEPTH; i++)
        begin
            y = (64'(i) * cle_pkg::LN2_Q32) / 64'(DEPTH);
            term = 64'd1 << 32;
            sum = 64'd1 << 32;
            for (int k = 1; k <= 20; k++)
            begin
                term = ((term * y) >> 32) / 64'(k);
                if (k % 2 == 1)
                    sum = sum - term;
                else
                    sum = sum + term;
            end
            pow2_rom[i] = sum;
        end
    endfunction

    // Interpolated 2^(-u) for a fraction u in Q0.F.
    function automatic logic [63:0] pow2_frac(input logic [63:0] u);
        logic [63:0] p;
        logic [63:0] i;
        logic [63:0] w;
        logic [63:0] t0;
        logic [63:0] t1;
        p = (u & ((64'd1 << FRAC) - 1)) * 64'(DEPTH);
        i = p >> FRAC;
        w = p & ((64'd1 << FRAC) - 1);
        t0 = pow2_rom[i];
        t1 = pow2_rom[i + 1];
        return t0 - (((t0 - t1) * w) >> FRAC);
    endfunction

    // Expected line-shape value and saturation flag for one abscissa.
    function automatic void predict_shape(input logic signed [31:0] x,
                                          output logic [31:0] val, output logic sat);
        longint       dd;
        longint       alpha;
        logic         left;
        logic         raise;
        logic [63:0]  dm;
        logic [63:0]  sq;
        logic [63:0]  sig;
        logic [63:0]  q;
        logic [63:0]  t;
        logic [63:0]  n;
        logic [63:0]  f;
        logic [63:0]  g;
        logic [63:0]  prod;
        logic [63:0]  v;
        logic [127:0] pos;
        logic [127:0] neg;
        logic [127:0] den;
        logic [127:0] num;
        logic [127:0] quo;
        int           m;
        int           sh;
        dd = longint'(x) - longint'(mean_q);
        left = dd < 0;
        dm = left ? 64'(-dd) : 64'(dd);
        sq = dm * dm;
        sig = left ? 64'(lwidth_q) : 64'(rwidth_q);
        pos = (128'(sig) * 128'(sig)) << (FRAC + 1);
        neg = '0;
        raise = 1'b0;
        if (left)
        begin
            alpha = longint'(tail_q);
            if (alpha >= 0)
                pos = pos + 128'(alpha) * 128'(sq);
            else
                neg = 128'(-alpha) * 128'(sq);
        end
        if (pos >= neg)
            den = pos - neg;
        else
        begin
            den = neg - pos;
            raise = 1'b1;
        end
        num = 128'(sq) << (2 * FRAC);
        if (den == 0)
            q = 0;
        else
        begin
            quo = num / den;
            if (quo >= (128'd1 << (FRAC + cle_pkg::RATIO_INT_BITS)))
                q = (64'd1 << (FRAC + cle_pkg::RATIO_INT_BITS)) - 1;
            else
                q = quo[63:0];
        end
        t = (q * cle_pkg::LOG2E_Q32 + (64'd1 << 31)) >> 32;
        n = t >> FRAC;
        f = t & ((64'd1 << FRAC) - 1);
        if (!raise)
        begin
            g = pow2_frac(f);
            m = -int'(n);
        end
        else if (f == 0)
        begin
            g = 64'd1 << 32;
            m = int'(n);
        end
        else
        begin
            g = pow2_frac((64'd1 << FRAC) - f);
            m = int'(n) + 1;
        end
        prod = 64'(height_q) * g;
        sat = 1'b0;
        if (m > 32)
        begin
            sat = prod != 0;
            val = sat ? 32'hFFFF_FFFF : 32'h0;
        end
        else
        begin
            sh = 32 - m;
            v = (sh >= 64) ? 64'd0 : (prod >> sh);
            if (v > 64'hFFFF_FFFF)
            begin
                sat = 1'b1;
                val = 32'hFFFF_FFFF;
            end
            else
                val = v[31:0];
        end
    endfunction

    // Record the expected word of every accepted sample.
    always @(posedge clk)
    begin
        logic [31:0] v;
        logic        s;
        if (rst_n && sample_valid && !sample_stall)
        begin
            predict_shape(sample_x, v, s);
            want_value_q.push_back(v);
            want_sat_q.push_back(s);
        end
    end

    // Compare each delivered word with the oldest expectation.
    always @(posedge clk)
    begin
        logic [31:0] v;
        logic        s;
        if (rst_n && result_valid && !result_stall)
        begin
            if (want_value_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: value %h sat %b", shape_value, saturated);
            end
            else
            begin
                v = want_value_q.pop_front();
                s = want_sat_q.pop_front();
                if (v !== shape_value || s !== saturated)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected value %h sat %b, got value %h sat %b",
                                 v, s, shape_value, saturated);
                end
            end
        end
    end

    // Output stall pattern, with an occasional long hold-off on request.
    always @(posedge clk)
    begin
        if (hold_cnt > 0)
        begin
            hold_cnt--;
            result_stall <= 1'b1;
        end
        else if (hold_req)
        begin
            hold_req = 0;
            hold_cnt = 250;
            result_stall <= 1'b1;
        end
        else
        begin
            if (mode_cnt == 0)
            begin
                stall_mode = $urandom_range(0, 2);
                mode_cnt = $urandom_range(20, 150);
            end
            else
                mode_cnt--;
            case (stall_mode)
                0: result_stall <= 1'b0;
                1: result_stall <= ($urandom_range(0, 99) < 40);
                default: result_stall <= (mode_cnt % 4 != 0);
            endcase
        end
    end

    // Run time limit.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_CAP)
        begin
            $display("cruijff_lineshape_eval regression: fail");
            $finish;
        end
    end

    // Offer one sample word, wait for it to be taken, then maybe pause.
    task automatic send_sample(input logic signed [31:0] x);
        int gap;
        sample_valid <= 1'b1;
        sample_x <= x;
        @(posedge clk);
        while (sample_stall)
            @(posedge clk);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap = $urandom_range(0, max_gap);
            if (gap > 0)
            begin
                sample_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        else
            burst_left--;
    endtask

    // Let the pipeline empty before the next register write.
    task automatic drain();
        sample_valid <= 1'b0;
        @(posedge clk);
        while (want_value_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            cle_pkg::REG_PEAK_MEAN:   mean_q = data;
            cle_pkg::REG_LEFT_WIDTH:  lwidth_q = data;
            cle_pkg::REG_RIGHT_WIDTH: rwidth_q = data;
            cle_pkg::REG_LEFT_TAIL:   tail_q = data;
            cle_pkg::REG_PEAK_HEIGHT: height_q = data;
            default: ;
        endcase
    endtask

    task automatic set_peak(input logic [31:0] mu, input logic [31:0] lw,
                            input logic [31:0] rw, input logic [31:0] al,
                            input logic [31:0] amp);
        write_reg(cle_pkg::REG_PEAK_MEAN, mu);
        write_reg(cle_pkg::REG_LEFT_WIDTH, lw);
        write_reg(cle_pkg::REG_RIGHT_WIDTH, rw);
        write_reg(cle_pkg::REG_LEFT_TAIL, al);
        write_reg(cle_pkg::REG_PEAK_HEIGHT, amp);
    endtask

    // Abscissa mostly within a few widths of the peak, sometimes anywhere.
    function automatic logic [31:0] pick_x();
        longint span;
        if ($urandom_range(0, 9) < 2)
            return $urandom;
        span = 4 * longint'(($urandom_range(0, 1) != 0) ? lwidth_q : rwidth_q) + 16;
        if (span > 64'h3FFF_FFFF)
            span = 64'h3FFF_FFFF;
        return 32'(longint'(mean_q) + longint'($urandom_range(0, 32'(2 * span))) - span);
    endfunction

    function automatic logic [31:0] pick_width();
        case ($urandom_range(0, 5))
            0: return 32'h0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom;
            default: return $urandom_range(32'h400, 32'h40_0000);
        endcase
    endfunction

    function automatic logic [31:0] pick_tail();
        case ($urandom_range(0, 5))
            0: return 32'h0;
            1: return $urandom;
            2: return 32'(-int'($urandom_range(1, 32'h4_0000)));
            3: return 32'h8000_0000;
            default: return $urandom_range(1, 32'h4_0000);
        endcase
    endfunction

    function automatic logic [31:0] pick_height();
        case ($urandom_range(0, 5))
            0: return 32'h0;
            1: return 32'hFFFF_FFFF;
            2: return ONE_Q;
            default: return $urandom;
        endcase
    endfunction

    // Extremes of the abscissa under the reset parameters.
    task automatic test_reset_values();
        send_sample(32'sh0);
        send_sample(32'sh1_0000);
        send_sample(-32'sh1_0000);
        send_sample(32'sh7FFF_FFFF);
        send_sample(32'sh8000_0000);
        send_sample(32'sh1);
        send_sample(-32'sh1);
        send_sample(32'sh5555_5555);
        send_sample(32'shAAAA_AAAA);
        drain();
    endtask

    // Zero denominator, negative tail, zero and full amplitude, spare index.
    task automatic test_special_peaks();
        set_peak(32'h0002_0000, 32'h0, 32'h0, 32'h0, 32'h0003_0000);
        send_sample(32'sh0002_0000);
        send_sample(32'sh0001_0000);
        send_sample(32'sh0003_0000);
        drain();
        set_peak(32'h0, 32'h1_0000, 32'h1_0000, 32'hFFFF_0000, 32'h1_0000);
        send_sample(-32'sh8000);
        send_sample(-32'sh1_0000);
        send_sample(-32'sh4_0000);
        send_sample(-32'sh40_0000);
        drain();
        set_peak(32'h8000_0000, 32'hFFFF_FFFF, 32'h1, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        send_sample(32'sh8000_0000);
        send_sample(32'sh7FFF_FFFF);
        send_sample(32'sh8000_0010);
        drain();
        set_peak(32'h7FFF_FFFF, 32'h100, 32'hFFFF_FFFF, 32'h8000_0000, 32'h0);
        send_sample(32'sh8000_0000);
        send_sample(32'sh7FFF_FF00);
        drain();
        write_reg(REG_SPARE, 32'h1234_5678);
        send_sample(32'sh7FFF_FFFF);
        drain();
    endtask

    // Random parameter sets, each followed by a run of samples.
    task automatic test_random_sweep();
        for (int ph = 0; ph < 14; ph++)
        begin
            set_peak($urandom, pick_width(), pick_width(), pick_tail(), pick_height());
            if (ph % 3 == 0)
                write_reg(cle_pkg::REG_PEAK_MEAN,
                          $urandom_range(0, 32'h10_0000) - 32'h8_0000);
            max_gap = (ph % 4 == 1) ? 0 : $urandom_range(1, 8);
            repeat (60)
                send_sample(pick_x());
            drain();
        end
    endtask

    // Long output hold-off while samples keep coming, so the input stalls.
    task automatic test_output_holdoff();
        set_peak(32'h0, 32'h2_0000, 32'h1_8000, 32'h4000, 32'h5_0000);
        max_gap = 0;
        hold_req = 1;
        repeat (100)
            send_sample(pick_x());
        drain();
    endtask

    initial
    begin
        build_pow2_rom();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_values();
        test_special_peaks();
        test_random_sweep();
        test_output_holdoff();
        if (mismatches == 0)
            $display("cruijff_lineshape_eval regression: pass");
        else
            $display("cruijff_lineshape_eval regression: fail");
        $finish;
    end

endmodule

`default_nettype wire
